### rtl/core/ess_pkg.sv
// ----------------------------------------------------------------------------
// ess_pkg
// Shared types and constants of the edge speed smoother: opcodes, register
// indexes, sequencer states and the divider request and response bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ess_pkg;

    localparam int NUM_EDGES  = 1024;
    localparam int MAX_STEPS  = 16;
    localparam int EDGE_W     = $clog2(NUM_EDGES);
    localparam int SLOT_W     = $clog2(MAX_STEPS);
    localparam int HIST_AW    = EDGE_W + SLOT_W;

    localparam int SPEED_W    = 16;
    localparam int SUM_W      = 20;
    localparam int STEPS_W    = 5;
    localparam int WEIGHT_W   = 17;
    localparam int LEN_W      = 24;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int DIV_W      = 32;
    localparam int DIVR_W     = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    localparam logic [SUM_W-1:0]    SUM_MAX    = SUM_W'(MAX_STEPS * 65535);
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
    localparam logic [STEPS_W-1:0]  STEPS_MAX  = STEPS_W'(MAX_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd2;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_FILL,
        ST_EMA,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

### rtl/core/ess_if.sv
// ----------------------------------------------------------------------------
// ess_in_if / ess_out_if
// Valid/ready channels of the edge speed smoother: operation requests in,
// smoothed speed and effort results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ess_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      op;
    logic [ess_pkg::EDGE_W-1:0]      edge_id;
    logic [ess_pkg::SPEED_W-1:0]     speed;
    logic [ess_pkg::LEN_W-1:0]       edge_length;
    logic [ess_pkg::TIME_W-1:0]      min_travel_time;

    modport source (
        output valid, op, edge_id, speed, edge_length, min_travel_time,
        input  ready
    );
    modport sink (
        input  valid, op, edge_id, speed, edge_length, min_travel_time,
        output ready
    );
endinterface

interface ess_out_if;
    logic                            valid;
    logic                            ready;
    logic [ess_pkg::SPEED_W-1:0]     smoothed_speed;
    logic [ess_pkg::TIME_W-1:0]      effort;
    logic                            saturated;

    modport source (
        output valid, smoothed_speed, effort, saturated,
        input  ready
    );
    modport sink (
        input  valid, smoothed_speed, effort, saturated,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/ess_div.sv
// ----------------------------------------------------------------------------
// ess_div
// Restoring unsigned divider, one quotient bit per cycle. Serves both the
// window average and the travel effort.
// ----------------------------------------------------------------------------
`default_nettype none

module ess_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ess_pkg::div_req_t req,
    output ess_pkg::div_rsp_t      rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [ess_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ess_pkg::DIV_W-1:0]         quo_reg, quo_next;
    logic [ess_pkg::DIVR_W-1:0]        rem_reg, rem_next;
    logic [ess_pkg::DIVR_W-1:0]        dsr_reg, dsr_next;
    logic [ess_pkg::DIVR_W:0]          shifted;
    logic [ess_pkg::DIVR_W+1:0]        trial;

    assign shifted = {rem_reg, quo_reg[ess_pkg::DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial[ess_pkg::DIVR_W+1])
            begin
                rem_next = shifted[ess_pkg::DIVR_W-1:0];
                quo_next = {quo_reg[ess_pkg::DIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[ess_pkg::DIVR_W-1:0];
                quo_next = {quo_reg[ess_pkg::DIV_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ess_pkg::DIV_CNT_W'(ess_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/core/edge_speed_smoother_core.sv
// ----------------------------------------------------------------------------
// edge_speed_smoother_core
// Per-edge speed smoothing (moving window or exponential average) with a
// travel effort query, built around one shared iterative divider.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  ---------+-----+--------------------------------------------------------
//  in_ch    | in  | op, edge_id, speed, edge_length, min_travel_time
//  out_ch   | out | smoothed_speed, effort, saturated (one per request)
//  cfg      | in  | cfg_we, cfg_index, cfg_data (mode, window_steps, weight)
//
//  One request at a time; in_ch.ready is high only while idle.
//  After accept: READ, EXEC, then FILL for init (16-entry history fill), EMA
//  for an EMA sample, DIV for window sample and query, and FINISH to load.
//  The result register lets the next request enter while a result waits.
//  Reset clears control and round slot; edge memories hold garbage until
//  their edge is initialized, so no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_speed_smoother_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [ess_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ess_pkg::CFG_DATA_W-1:0]     cfg_data,
    ess_in_if.sink                                  in_ch,
    ess_out_if.source                               out_ch
);

    ess_pkg::state_t                    state_reg, state_next;

    logic                               mode_reg;
    logic [ess_pkg::STEPS_W-1:0]        win_reg;
    logic [ess_pkg::WEIGHT_W-1:0]       wgt_reg;
    logic [ess_pkg::SLOT_W-1:0]         slot_reg;
    logic [ess_pkg::SLOT_W-1:0]         fill_reg;

    ess_pkg::op_t                       op_reg;
    logic [ess_pkg::EDGE_W-1:0]         id_reg;
    logic [ess_pkg::SPEED_W-1:0]        spd_reg;
    logic [ess_pkg::LEN_W-1:0]          len_reg;
    logic [ess_pkg::TIME_W-1:0]         mtt_reg;

    logic signed [34:0]                 mul_reg;
    logic [ess_pkg::SPEED_W-1:0]        res_speed_reg;
    logic [ess_pkg::TIME_W-1:0]         res_effort_reg;

    logic                               out_valid_reg;
    logic [ess_pkg::SPEED_W-1:0]        out_speed_reg;
    logic [ess_pkg::TIME_W-1:0]         out_effort_reg;
    logic                               out_sat_reg;

    logic [ess_pkg::SPEED_W-1:0]        es_mem [0:ess_pkg::NUM_EDGES-1];
    logic [ess_pkg::SUM_W-1:0]          ws_mem [0:ess_pkg::NUM_EDGES-1];
    logic [ess_pkg::SPEED_W-1:0]        hist_mem [0:ess_pkg::NUM_EDGES*ess_pkg::MAX_STEPS-1];
    logic [ess_pkg::SPEED_W-1:0]        es_rd_reg;
    logic [ess_pkg::SUM_W-1:0]          ws_rd_reg;
    logic [ess_pkg::SPEED_W-1:0]        hist_rd_reg;

    logic                               es_we;
    logic [ess_pkg::SPEED_W-1:0]        es_wdata;
    logic                               ws_we;
    logic [ess_pkg::SUM_W-1:0]          ws_wdata;
    logic                               hist_we;
    logic [ess_pkg::HIST_AW-1:0]        hist_waddr;
    logic [ess_pkg::HIST_AW-1:0]        hist_raddr;

    logic                               in_fire;
    logic                               out_load;
    logic [ess_pkg::STEPS_W-1:0]        steps;
    logic [ess_pkg::SLOT_W:0]           slot_inc;
    logic [ess_pkg::SUM_W-1:0]          ws_init;
    logic [ess_pkg::SUM_W-1:0]          sum_sub;
    logic [ess_pkg::SUM_W:0]            sum_add;
    logic [ess_pkg::SUM_W-1:0]          sum_new;
    logic [ess_pkg::WEIGHT_W-1:0]       wgt_eff;
    logic signed [ess_pkg::SPEED_W:0]   spd_diff;
    logic signed [34:0]                 ema_total;
    logic [ess_pkg::SPEED_W-1:0]        ema_v;
    logic [ess_pkg::SPEED_W-1:0]        avg_clamp;
    logic [ess_pkg::TIME_W-1:0]         effort_max;
    logic [ess_pkg::DIVR_W-1:0]         query_dsr;

    ess_pkg::div_req_t                  div_req;
    ess_pkg::div_rsp_t                  div_rsp;

    ess_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_load = (state_reg == ess_pkg::ST_FINISH) && (!out_valid_reg || out_ch.ready);

    // ---- datapath arithmetic ----
    always_comb
    begin
        priority if (win_reg == '0)
            steps = ess_pkg::STEPS_W'(1);
        else if (win_reg > ess_pkg::STEPS_MAX)
            steps = ess_pkg::STEPS_MAX;
        else
            steps = win_reg;
    end

    assign slot_inc = {1'b0, slot_reg} + 1'b1;
    assign ws_init  = ess_pkg::SUM_W'({4'b0, spd_reg} * ess_pkg::SUM_W'(steps));

    assign sum_sub = (ws_rd_reg >= {4'b0, hist_rd_reg}) ? ws_rd_reg - {4'b0, hist_rd_reg} : '0;
    assign sum_add = {1'b0, sum_sub} + {5'b0, spd_reg};
    assign sum_new = (sum_add > {1'b0, ess_pkg::SUM_MAX}) ? ess_pkg::SUM_MAX
                                                         : sum_add[ess_pkg::SUM_W-1:0];

    assign wgt_eff   = (wgt_reg > ess_pkg::WEIGHT_ONE) ? ess_pkg::WEIGHT_ONE : wgt_reg;
    assign spd_diff  = $signed({1'b0, es_rd_reg}) - $signed({1'b0, spd_reg});
    assign ema_total = $signed({3'b0, spd_reg, 16'b0}) + mul_reg + 35'sd32768;
    assign ema_v     = ema_total[31:16];

    assign avg_clamp  = (div_rsp.quotient > 32'd65535) ? 16'hFFFF
                                                       : div_rsp.quotient[ess_pkg::SPEED_W-1:0];
    assign effort_max = (div_rsp.quotient > mtt_reg) ? div_rsp.quotient : mtt_reg;
    assign query_dsr  = (es_rd_reg == '0) ? 16'd1 : es_rd_reg;

    assign hist_raddr = {id_reg, slot_reg};

    // ---- sequencer: next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ess_pkg::ST_IDLE:
                if (in_fire)
                    state_next = ess_pkg::ST_READ;
            ess_pkg::ST_READ:
                state_next = ess_pkg::ST_EXEC;
            ess_pkg::ST_EXEC:
                unique case (op_reg)
                    ess_pkg::OP_INIT:    state_next = ess_pkg::ST_FILL;
                    ess_pkg::OP_SAMPLE:  state_next = mode_reg ? ess_pkg::ST_DIV
                                                               : ess_pkg::ST_EMA;
                    ess_pkg::OP_ADVANCE: state_next = ess_pkg::ST_FINISH;
                    ess_pkg::OP_QUERY:   state_next = ess_pkg::ST_DIV;
                    default:             state_next = ess_pkg::ST_FINISH;
                endcase
            ess_pkg::ST_FILL:
                if (fill_reg == ess_pkg::SLOT_W'(ess_pkg::MAX_STEPS - 1))
                    state_next = ess_pkg::ST_FINISH;
            ess_pkg::ST_EMA:
                state_next = ess_pkg::ST_FINISH;
            ess_pkg::ST_DIV:
                if (div_rsp.done)
                    state_next = ess_pkg::ST_FINISH;
            ess_pkg::ST_FINISH:
                if (out_load)
                    state_next = ess_pkg::ST_IDLE;
            default:
                state_next = ess_pkg::ST_IDLE;
        endcase
    end

    // ---- sequencer: outputs ----
    always_comb
    begin
        in_ch.ready      = (state_reg == ess_pkg::ST_IDLE);
        es_we            = 1'b0;
        es_wdata         = spd_reg;
        ws_we            = 1'b0;
        ws_wdata         = ws_init;
        hist_we          = 1'b0;
        hist_waddr       = {id_reg, slot_reg};
        div_req.start    = 1'b0;
        div_req.dividend = {len_reg, 8'b0};
        div_req.divisor  = query_dsr;
        unique case (state_reg)
            ess_pkg::ST_EXEC:
                unique case (op_reg)
                    ess_pkg::OP_INIT:
                    begin
                        es_we = 1'b1;
                        ws_we = 1'b1;
                    end
                    ess_pkg::OP_SAMPLE:
                        if (mode_reg)
                        begin
                            ws_we            = 1'b1;
                            ws_wdata         = sum_new;
                            hist_we          = 1'b1;
                            div_req.start    = 1'b1;
                            div_req.dividend = {12'b0, sum_new};
                            div_req.divisor  = {11'b0, steps};
                        end
                    ess_pkg::OP_QUERY:
                        div_req.start = 1'b1;
                    default:
                    begin
                    end
                endcase
            ess_pkg::ST_FILL:
            begin
                hist_we    = 1'b1;
                hist_waddr = {id_reg, fill_reg};
            end
            ess_pkg::ST_EMA:
            begin
                es_we    = 1'b1;
                es_wdata = ema_v;
            end
            ess_pkg::ST_DIV:
                if (div_rsp.done && op_reg == ess_pkg::OP_SAMPLE)
                begin
                    es_we    = 1'b1;
                    es_wdata = avg_clamp;
                end
            default:
            begin
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ess_pkg::ST_IDLE;
            mode_reg      <= 1'b0;
            win_reg       <= ess_pkg::STEPS_W'(1);
            wgt_reg       <= ess_pkg::WEIGHT_W'(32768);
            slot_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ess_pkg::CFG_MODE:   mode_reg <= cfg_data[0];
                    ess_pkg::CFG_WINDOW: win_reg  <= cfg_data[ess_pkg::STEPS_W-1:0];
                    ess_pkg::CFG_WEIGHT: wgt_reg  <= cfg_data[ess_pkg::WEIGHT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ess_pkg::ST_EXEC && op_reg == ess_pkg::OP_ADVANCE)
                slot_reg <= (slot_inc >= steps) ? '0 : slot_inc[ess_pkg::SLOT_W-1:0];
            if (state_reg == ess_pkg::ST_EXEC)
                fill_reg <= '0;
            else if (state_reg == ess_pkg::ST_FILL)
                fill_reg <= fill_reg + 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= ess_pkg::op_t'(in_ch.op);
            id_reg  <= in_ch.edge_id;
            spd_reg <= in_ch.speed;
            len_reg <= in_ch.edge_length;
            mtt_reg <= in_ch.min_travel_time;
        end
        if (state_reg == ess_pkg::ST_EXEC)
        begin
            mul_reg <= 35'(spd_diff * $signed({1'b0, wgt_eff}));
            unique case (op_reg)
                ess_pkg::OP_INIT:    res_speed_reg <= spd_reg;
                ess_pkg::OP_SAMPLE:  res_speed_reg <= es_rd_reg;
                ess_pkg::OP_ADVANCE: res_speed_reg <= '0;
                ess_pkg::OP_QUERY:   res_speed_reg <= es_rd_reg;
                default:             res_speed_reg <= '0;
            endcase
            res_effort_reg <= '0;
        end
        else if (state_reg == ess_pkg::ST_EMA)
            res_speed_reg <= ema_v;
        else if (state_reg == ess_pkg::ST_DIV && div_rsp.done)
        begin
            if (op_reg == ess_pkg::OP_SAMPLE)
                res_speed_reg <= avg_clamp;
            else
                res_effort_reg <= effort_max;
        end
        if (out_load)
        begin
            out_speed_reg  <= res_speed_reg;
            out_effort_reg <= res_effort_reg;
            // quotient of a 32-bit dividend always fits; clamp never fires
            out_sat_reg    <= 1'b0;
        end
    end

    // ---- edge memories ----
    always_ff @(posedge clk)
    begin
        if (es_we)
            es_mem[id_reg] <= es_wdata;
        es_rd_reg <= es_mem[id_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ws_we)
            ws_mem[id_reg] <= ws_wdata;
        ws_rd_reg <= ws_mem[id_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= spd_reg;
        hist_rd_reg <= hist_mem[hist_raddr];
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.smoothed_speed = out_speed_reg;
    assign out_ch.effort         = out_effort_reg;
    assign out_ch.saturated      = out_sat_reg;

    // ---- assertions ----
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ess_pkg::ST_READ))
        else $error("accepted transaction did not start a memory read");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ess_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    a_slot_moves_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_reg != $past(slot_reg)) |->
            ($past(state_reg) == ess_pkg::ST_EXEC && $past(op_reg) == ess_pkg::OP_ADVANCE))
        else $error("round slot changed without an advance");

    a_fill_only_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ess_pkg::ST_FILL) |-> (op_reg == ess_pkg::OP_INIT))
        else $error("history fill outside an init");

endmodule

`default_nettype wire

### dv/ess_smoothing_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ess_smoothing_checker
// Watches the request, result and register ports of the edge speed smoother.
// Every accepted request goes through a private model of the per-edge speed
// store, window sums, history rows and shared round slot. The model's report
// joins a queue, and each accepted result is compared against the oldest one.
// ----------------------------------------------------------------------------

module ess_smoothing_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ess_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ess_pkg::CFG_DATA_W-1:0]  cfg_data,
    ess_in_if                               in_ch,
    ess_out_if                              out_ch,
    output int                              mismatches,
    output int                              outstanding,
    output int                              compared
);

    import ess_pkg::*;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [TIME_W-1:0]  effort;
        logic               saturated;
    } edge_report_t;

    logic [SPEED_W-1:0]  speed_mem   [NUM_EDGES];
    logic [SUM_W-1:0]    sum_mem     [NUM_EDGES];
    logic [SPEED_W-1:0]  history_mem [NUM_EDGES*MAX_STEPS];
    logic [SLOT_W-1:0]   slot;
    logic                mode_q;
    logic [STEPS_W-1:0]  steps_q;
    logic [WEIGHT_W-1:0] weight_q;

    edge_report_t reports_due[$];
    int errs   = 0;
    int checks = 0;

    function automatic edge_report_t apply_op(op_t op, logic [EDGE_W-1:0] id,
                                              logic [SPEED_W-1:0] spd,
                                              logic [LEN_W-1:0] len,
                                              logic [TIME_W-1:0] mtt);
        edge_report_t      r;
        int unsigned       steps;
        int unsigned       nx;
        longint unsigned   s;
        longint unsigned   old;
        longint unsigned   fresh;
        longint unsigned   w;
        longint unsigned   v;
        longint unsigned   divisor;
        longint unsigned   quotient;
        r = '0;
        fresh = spd;
        steps = (steps_q == 0) ? 1 : (steps_q > MAX_STEPS) ? MAX_STEPS : steps_q;
        case (op)
            OP_ADVANCE:
            begin
                nx = slot + 1;
                slot = (nx >= steps) ? '0 : SLOT_W'(nx);
                return r;
            end
            OP_INIT:
            begin
                speed_mem[id] = spd;
                for (int k = 0; k < MAX_STEPS; k++)
                    history_mem[{id, SLOT_W'(k)}] = spd;
                sum_mem[id] = SUM_W'(fresh * steps);
            end
            OP_SAMPLE:
            begin
                if (mode_q)
                begin
                    s = sum_mem[id];
                    old = history_mem[{id, slot}];
                    s = (s >= old) ? s - old : 0;
                    s = s + fresh;
                    if (s > SUM_MAX)
                        s = SUM_MAX;
                    sum_mem[id] = SUM_W'(s);
                    history_mem[{id, slot}] = spd;
                    v = s / steps;
                    if (v > 65535)
                        v = 65535;
                    speed_mem[id] = SPEED_W'(v);
                end
                else
                begin
                    w = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
                    old = speed_mem[id];
                    if (fresh != old)
                    begin
                        v = (old * w + fresh * (65536 - w) + 32768) >> 16;
                        if (v > 65535)
                            v = 65535;
                        speed_mem[id] = SPEED_W'(v);
                    end
                end
            end
            default:
            begin
                divisor = speed_mem[id];
                if (divisor < 1)
                    divisor = 1;
                quotient = (longint'(len) * 256) / divisor;
                if (mtt > quotient)
                    quotient = mtt;
                if (quotient > 64'hFFFF_FFFF)
                begin
                    quotient = 64'hFFFF_FFFF;
                    r.saturated = 1'b1;
                end
                r.effort = TIME_W'(quotient);
            end
        endcase
        r.speed = speed_mem[id];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        edge_report_t want;
        edge_report_t got;
        edge_report_t due;
        if (!rst_n)
        begin
            slot = '0;
            mode_q = 1'b0;
            steps_q = STEPS_W'(1);
            weight_q = WEIGHT_W'(32768);
            reports_due.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                checks++;
                got = '{out_ch.smoothed_speed, out_ch.effort, out_ch.saturated};
                if (reports_due.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: unexpected result speed %0d effort %0d sat %0b",
                                 $time, got.speed, got.effort, got.saturated);
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (got !== want)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("%0t: speed/effort/sat expected %0d/%0d/%0b got %0d/%0d/%0b",
                                     $time, want.speed, want.effort, want.saturated,
                                     got.speed, got.effort, got.saturated);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:   mode_q = cfg_data[0];
                    CFG_WINDOW: steps_q = cfg_data[STEPS_W-1:0];
                    CFG_WEIGHT: weight_q = cfg_data[WEIGHT_W-1:0];
                    default:    ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                due = apply_op(op_t'(in_ch.op), in_ch.edge_id, in_ch.speed,
                               in_ch.edge_length, in_ch.min_travel_time);
                reports_due.insert(reports_due.size(), due);
            end
        end
        mismatches  <= errs;
        outstanding <= reports_due.size();
        compared    <= checks;
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives edge_speed_smoother_core through a short directed sequence (extreme
// speeds, lengths and times, unchanged EMA samples, window changes after
// init, sum and average clamping) and then several randomized phases, each
// under its own register setting, with random gaps on both channels except in one steady phase.
// ----------------------------------------------------------------------------

module testbench;

    import ess_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOT_EDGES       = 12;
    localparam int IDLE_PCT        = 21;
    localparam int DRAIN_CYCLES    = 40;
    localparam int STALL_LIMIT     = 4000;

    localparam int PHASE_MODE   [NUM_PHASES] = '{0, 1, 1, 0, 1, 0, 0, 1};
    localparam int PHASE_STEPS  [NUM_PHASES] = '{1, 16, 4, 7, 0, 31, 16, 9};
    localparam int PHASE_WEIGHT [NUM_PHASES] =
        '{32768, 0, 65536, 65535, 100000, 1, 0, 131071};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  steady;

    int mismatches;
    int outstanding;
    int compared;
    int stall_cycles = 0;
    int settings_used = 1;
    int op_count [4];

    bit                  initialized [NUM_EDGES];
    bit [SPEED_W-1:0]    last_speed  [NUM_EDGES];
    logic [EDGE_W-1:0]   hot_edge    [HOT_EDGES];

    ess_in_if  in_ch ();
    ess_out_if out_ch ();

    edge_speed_smoother_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    ess_smoothing_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send(op_t op, logic [EDGE_W-1:0] id, logic [SPEED_W-1:0] spd,
                        logic [LEN_W-1:0] len, logic [TIME_W-1:0] mtt);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.op              <= op;
        in_ch.edge_id         <= id;
        in_ch.speed           <= spd;
        in_ch.edge_length     <= len;
        in_ch.min_travel_time <= mtt;
        if (op == OP_INIT)
            initialized[id] = 1'b1;
        if (op == OP_INIT || op == OP_SAMPLE)
            last_speed[id] = spd;
        op_count[int'(op)]++;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic m, logic [STEPS_W-1:0] steps,
                             logic [WEIGHT_W-1:0] weight);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data  <= {16'($urandom), m};
        @(posedge clk);
        cfg_index <= CFG_WINDOW;
        cfg_data  <= {12'($urandom), steps};
        @(posedge clk);
        cfg_index <= CFG_WEIGHT;
        cfg_data  <= weight;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int unsigned       pick;
        op_t               op;
        logic [EDGE_W-1:0] id;
        logic [SPEED_W-1:0] spd;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] mtt;

        rst_n                 = 1'b0;
        steady                = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_MODE;
        cfg_data              = '0;
        in_ch.valid           = 1'b0;
        in_ch.op              = OP_INIT;
        in_ch.edge_id         = '0;
        in_ch.speed           = '0;
        in_ch.edge_length     = '0;
        in_ch.min_travel_time = '0;
        out_ch.ready          = 1'b0;
        for (int k = 0; k < HOT_EDGES; k++)
            hot_edge[k] = EDGE_W'($urandom_range(NUM_EDGES - 1));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_INIT,    10'd0,    16'd0,     24'd0,        32'd0);
        send(OP_INIT,    10'd1023, 16'hFFFF,  24'd0,        32'd0);
        send(OP_INIT,    10'd5,    16'd1000,  24'd0,        32'd0);
        send(OP_QUERY,   10'd0,    16'd0,     24'hFF_FFFF,  32'd0);
        send(OP_QUERY,   10'd1023, 16'd0,     24'd0,        32'hFFFF_FFFF);
        send(OP_QUERY,   10'd5,    16'd0,     24'd12345,    32'd100);
        send(OP_SAMPLE,  10'd5,    16'd1000,  24'd0,        32'd0);
        send(OP_SAMPLE,  10'd5,    16'd3001,  24'd0,        32'd0);
        send(OP_SAMPLE,  10'd1023, 16'd0,     24'd0,        32'd0);
        send(OP_ADVANCE, 10'd0,    16'd0,     24'd0,        32'd0);
        settle();
        configure(1'b1, 5'd16, 17'd0);
        send(OP_INIT,    10'd682,  16'hFFFF,  24'd0,        32'd0);
        send(OP_SAMPLE,  10'd682,  16'd0,     24'd0,        32'd0);
        send(OP_ADVANCE, 10'd341,  16'hFFFF,  24'hFF_FFFF,  32'hFFFF_FFFF);
        send(OP_SAMPLE,  10'd682,  16'd12345, 24'd0,        32'd0);
        send(OP_SAMPLE,  10'd1023, 16'd0,     24'd0,        32'd0);
        send(OP_ADVANCE, 10'd0,    16'd0,     24'd0,        32'd0);
        send(OP_SAMPLE,  10'd1023, 16'd0,     24'd0,        32'd0);
        send(OP_QUERY,   10'd682,  16'd0,     24'd341,      32'd1);
        settle();
        configure(1'b1, 5'd0, 17'd65536);
        send(OP_SAMPLE,  10'd682,  16'hFFFF,  24'd0,        32'd0);
        send(OP_ADVANCE, 10'd0,    16'd0,     24'd0,        32'd0);
        send(OP_QUERY,   10'd682,  16'd0,     24'hFF_FFFF,  32'd0);
        settle();
        configure(1'b0, 5'd31, 17'h1_FFFF);
        send(OP_SAMPLE,  10'd5,    16'd0,     24'd0,        32'd0);
        send(OP_INIT,    10'd341,  16'd1,     24'd0,        32'd0);
        send(OP_QUERY,   10'd341,  16'd0,     24'hFF_FFFF,  32'd0);
        settle();
        configure(1'b0, 5'd1, 17'd0);
        send(OP_SAMPLE,  10'd341,  16'd40000, 24'd0,        32'd0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            configure(PHASE_MODE[p][0], STEPS_W'(PHASE_STEPS[p]),
                      WEIGHT_W'(PHASE_WEIGHT[p]));
            steady = (p == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(9) == 0)
                    id = EDGE_W'($urandom);
                else
                    id = hot_edge[$urandom_range(HOT_EDGES - 1)];
                pick = $urandom_range(99);
                op = (pick < 10) ? OP_INIT : (pick < 55) ? OP_SAMPLE :
                     (pick < 72) ? OP_ADVANCE : OP_QUERY;
                if ((op == OP_SAMPLE || op == OP_QUERY) && !initialized[id])
                    op = OP_INIT;
                case ($urandom_range(9))
                    0:       spd = '0;
                    1:       spd = '1;
                    2:       spd = last_speed[id];
                    3, 4:    spd = SPEED_W'($urandom_range(3000));
                    default: spd = SPEED_W'($urandom);
                endcase
                case ($urandom_range(7))
                    0:       len = '0;
                    1:       len = '1;
                    default: len = LEN_W'($urandom);
                endcase
                case ($urandom_range(9))
                    0:       mtt = '0;
                    1:       mtt = '1;
                    2, 3:    mtt = $urandom;
                    default: mtt = $urandom_range(32'h000F_FFFF);
                endcase
                send(op, id, spd, len, mtt);
            end
        end
        steady = 1'b0;
        settle();

        $display("Sent %0d init, %0d sample, %0d advance and %0d query requests",
                 op_count[int'(OP_INIT)], op_count[int'(OP_SAMPLE)],
                 op_count[int'(OP_ADVANCE)], op_count[int'(OP_QUERY)]);
        $display("Compared %0d results under %0d register settings, %0d mismatches",
                 compared, settings_used, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
